/* hdl/srp_pkg.sv */
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and constants for the semicolon record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package srp_pkg;

    // one input word: a byte of the text line plus end-of-line marker
    typedef struct packed {
        logic [7:0] char_in;
        logic       line_last;
    } t_in_word;

    // one result word: status and the parsed record
    typedef struct packed {
        logic [1:0]        status;
        logic [15:0]       year_out;
        logic [3:0]        month_out;
        logic [4:0]        day_out;
        logic [4:0]        hour_out;
        logic [5:0]        minute_out;
        logic signed [7:0] temp_out;
    } t_out_word;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FORMAT = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // characters
    localparam logic [7:0] CH_SEP     = 8'h3B;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    // field positions
    localparam logic [2:0] FLD_YEAR   = 3'd0;
    localparam logic [2:0] FLD_MONTH  = 3'd1;
    localparam logic [2:0] FLD_DAY    = 3'd2;
    localparam logic [2:0] FLD_HOUR   = 3'd3;
    localparam logic [2:0] FLD_MINUTE = 3'd4;
    localparam logic [2:0] FLD_TEMP   = 3'd5;

    // field limits
    localparam logic [19:0] SAT_MAG    = 20'd999;
    localparam logic [15:0] MONTH_MAX  = 16'd12;
    localparam logic [15:0] DAY_MAX    = 16'd31;
    localparam logic [15:0] HOUR_MAX   = 16'd23;
    localparam logic [15:0] MINUTE_MAX = 16'd59;
    localparam logic [15:0] TEMP_MAX   = 16'd99;

endpackage

`default_nettype wire

/* hdl/srp_out_skid.sv */
// ----------------------------------------------------------------------------
// srp_out_skid
// Result register with one skid entry; upstream stall is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module srp_out_skid import srp_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_word i_data,
    input  wire logic      i_stall,
    output logic           o_valid,
    output t_out_word      o_data,
    output logic           o_full
);

    logic      r_valid;
    logic      r_skid_valid;
    t_out_word r_data;
    t_out_word r_skid_data;
    logic      take;

    assign take = r_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_data       <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_valid || take) begin
            r_valid <= i_push;
            if (i_push) begin
                r_data <= i_data;
            end
        end else if (i_push) begin
            r_skid_data  <= i_data;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_full  = r_skid_valid;

endmodule

`default_nettype wire

/* hdl/semicolon_record_parser.sv */
// ----------------------------------------------------------------------------
// semicolon_record_parser
// Byte-serial parser for "year;month;day;hour;minute;temperature" lines.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload     | handshake
//  --------+-----------+-------------+------------------------------------
//  in      | input     | t_in_word   | i_in_valid / o_in_stall
//  out     | output    | t_out_word  | o_out_valid / i_out_stall
//
//  One word is taken per cycle while o_in_stall is low; each byte is folded
//  into the parse state in the cycle it is accepted (one multiply-by-ten
//  and add, plus compares). The record of the word carrying line_last is
//  registered on o_out_*, or in the skid entry behind a stalled record.
//  Reset clears the parse state and empties the result register and skid.
//  o_in_stall rises only when both result register and skid entry hold
//  records, i.e. after a record met a stalled output; driven from a flop.
// ----------------------------------------------------------------------------
`default_nettype none

module semicolon_record_parser import srp_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_word i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output t_out_word     o_out_data,
    input  wire logic     i_out_stall
);

    // scan phases within a field
    localparam logic [1:0] PH_START = 2'd0;   // awaiting field start
    localparam logic [1:0] PH_SIGN  = 2'd1;   // sign seen, digit needed
    localparam logic [1:0] PH_DIGIT = 2'd2;   // inside digits
    localparam logic [1:0] PH_DONE  = 2'd3;   // temperature finished

    // parse state
    logic [2:0]  r_field, n_field;
    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_accum, n_accum;
    logic        r_minus, n_minus;
    logic [15:0] r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day, n_day;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [1:0]  r_fail, n_fail;
    logic        r_at_start, n_at_start;
    logic        r_skip, n_skip;

    logic        in_acc;
    logic        push;
    t_out_word   rec;
    logic        skid_full;

    // byte classification
    logic [7:0]  c;
    logic        is_digit;
    logic        is_space;
    logic [3:0]  digit;
    logic [19:0] prod;
    logic [15:0] acc_next;
    logic        bad;
    logic [1:0]  status;

    assign c        = i_in_data.char_in;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign digit    = 4'(c - CH_ZERO);

    // accumulator times ten plus digit; year wraps, others saturate at 999
    assign prod = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0} + {16'd0, digit};
    assign acc_next = (r_field == FLD_YEAR) ? prod[15:0]
                    : ((prod > SAT_MAG) ? SAT_MAG[15:0] : prod[15:0]);

    // range check of the field closed by a separator
    always_comb begin
        case (r_field)
            FLD_YEAR:   bad = 1'b0;
            FLD_MONTH:  bad = (r_accum == 16'd0) || (r_accum > MONTH_MAX);
            FLD_DAY:    bad = (r_accum == 16'd0) || (r_accum > DAY_MAX);
            FLD_HOUR:   bad = (r_accum > HOUR_MAX);
            default:    bad = (r_accum > MINUTE_MAX);
        endcase
    end

    assign in_acc = i_in_valid & ~o_in_stall;

    always_comb begin
        n_field    = r_field;
        n_phase    = r_phase;
        n_accum    = r_accum;
        n_minus    = r_minus;
        n_year     = r_year;
        n_month    = r_month;
        n_day      = r_day;
        n_hour     = r_hour;
        n_minute   = r_minute;
        n_fail     = r_fail;
        n_at_start = 1'b0;
        n_skip     = r_skip | (r_at_start & ((c == CH_HASH) || (c == CH_NEWLINE)));
        push       = 1'b0;
        status     = ST_OK;
        rec        = '0;

        // fold one byte into the parse state; format failure freezes it
        if (!n_skip && (r_fail != ST_FORMAT) && (r_phase != PH_DONE)) begin
            case (r_phase)
                PH_START: begin
                    if (is_space) begin
                        n_phase = PH_START;
                    end else if (c == CH_PLUS) begin
                        n_phase = PH_SIGN;
                    end else if (c == CH_MINUS) begin
                        if (r_field == FLD_TEMP) begin
                            n_minus = 1'b1;
                            n_phase = PH_SIGN;
                        end else begin
                            n_fail = ST_FORMAT;
                        end
                    end else if (is_digit) begin
                        n_accum = {12'd0, digit};
                        n_phase = PH_DIGIT;
                    end else begin
                        n_fail = ST_FORMAT;
                    end
                end
                PH_SIGN: begin
                    if (is_digit) begin
                        n_accum = {12'd0, digit};
                        n_phase = PH_DIGIT;
                    end else begin
                        n_fail = ST_FORMAT;
                    end
                end
                default: begin
                    if (is_digit) begin
                        n_accum = acc_next;
                    end else if (r_field >= FLD_TEMP) begin
                        n_phase = PH_DONE;      // trailing text ignored
                    end else if (c != CH_SEP) begin
                        n_fail = ST_FORMAT;
                    end else begin
                        case (r_field)
                            FLD_YEAR:   n_year   = r_accum;
                            FLD_MONTH:  n_month  = bad ? 4'd0 : r_accum[3:0];
                            FLD_DAY:    n_day    = bad ? 5'd0 : r_accum[4:0];
                            FLD_HOUR:   n_hour   = bad ? 5'd0 : r_accum[4:0];
                            default:    n_minute = bad ? 6'd0 : r_accum[5:0];
                        endcase
                        if (bad && (r_fail == ST_OK)) begin
                            n_fail = ST_RANGE;
                        end
                        n_field = 3'(r_field + 3'd1);
                        n_phase = PH_START;
                        n_accum = 16'd0;
                        n_minus = 1'b0;
                    end
                end
            endcase
        end

        // end of line: build the record, then return to the line-start state
        if (i_in_data.line_last) begin
            push = ~n_skip;
            if ((n_fail == ST_FORMAT) || (n_field != FLD_TEMP) ||
                (n_phase == PH_START) || (n_phase == PH_SIGN)) begin
                status = ST_FORMAT;
            end else if ((n_accum > TEMP_MAX) || (n_fail == ST_RANGE)) begin
                status = ST_RANGE;
            end else begin
                status = ST_OK;
            end
            rec.status = status;
            if (status == ST_OK) begin
                rec.year_out   = n_year;
                rec.month_out  = n_month;
                rec.day_out    = n_day;
                rec.hour_out   = n_hour;
                rec.minute_out = n_minute;
                rec.temp_out   = n_minus ? 8'(8'd0 - n_accum[7:0]) : n_accum[7:0];
            end
            n_field    = FLD_YEAR;
            n_phase    = PH_START;
            n_accum    = 16'd0;
            n_minus    = 1'b0;
            n_year     = 16'd0;
            n_month    = 4'd0;
            n_day      = 5'd0;
            n_hour     = 5'd0;
            n_minute   = 6'd0;
            n_fail     = ST_OK;
            n_at_start = 1'b1;
            n_skip     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field    <= FLD_YEAR;
            r_phase    <= PH_START;
            r_accum    <= 16'd0;
            r_minus    <= 1'b0;
            r_year     <= 16'd0;
            r_month    <= 4'd0;
            r_day      <= 5'd0;
            r_hour     <= 5'd0;
            r_minute   <= 6'd0;
            r_fail     <= ST_OK;
            r_at_start <= 1'b1;
            r_skip     <= 1'b0;
        end else if (in_acc) begin
            r_field    <= n_field;
            r_phase    <= n_phase;
            r_accum    <= n_accum;
            r_minus    <= n_minus;
            r_year     <= n_year;
            r_month    <= n_month;
            r_day      <= n_day;
            r_hour     <= n_hour;
            r_minute   <= n_minute;
            r_fail     <= n_fail;
            r_at_start <= n_at_start;
            r_skip     <= n_skip;
        end
    end

    // result register plus skid entry
    srp_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_acc & push),
        .i_data  (rec),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_full  (skid_full)
    );

    assign o_in_stall = skid_full;

endmodule

`default_nettype wire

/* hdl/srp_chk.sv */
// ----------------------------------------------------------------------------
// srp_chk
// Port-level checks for the semicolon record parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srp_chk import srp_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire t_out_word o_out_data,
    input wire logic      i_out_stall
);

    // a stalled record holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled record changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK) ||
                        (o_out_data.status == ST_FORMAT) ||
                        (o_out_data.status == ST_RANGE))
        else $error("bad status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |->
            (o_out_data.year_out == 16'd0) && (o_out_data.month_out == 4'd0) &&
            (o_out_data.day_out == 5'd0) && (o_out_data.hour_out == 5'd0) &&
            (o_out_data.minute_out == 6'd0) && (o_out_data.temp_out == 8'sd0))
        else $error("failed record carries data");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_OK) |->
            (o_out_data.month_out >= 4'd1) && (o_out_data.month_out <= 4'd12) &&
            (o_out_data.day_out >= 5'd1) && (o_out_data.hour_out <= 5'd23) &&
            (o_out_data.minute_out <= 6'd59) &&
            (o_out_data.temp_out >= -8'sd99) && (o_out_data.temp_out <= 8'sd99))
        else $error("ok record out of range");

    // input stall only follows a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

endmodule

bind semicolon_record_parser srp_chk u_srp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the semicolon record parser. Text lines are fed one
// byte per word; a behavioural predictor works out the record each line should
// give, and every record leaving the block is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import srp_pkg::*;

    // random part ends once both figures are reached
    localparam int unsigned RANDOM_WORDS   = 190;
    localparam int unsigned RANDOM_RECORDS = 8;
    // watchdog limit for the whole run of about 600 words
    localparam int unsigned CYCLE_LIMIT    = 200_000;
    // margin for a stray record to pass the result register and the skid
    localparam int unsigned SETTLE_CYCLES  = 16;

    // where the predictor is within the current field
    typedef enum logic [1:0] {
        SCAN_START,     // waiting for the field's first character
        SCAN_SIGN,      // sign taken, digit must follow
        SCAN_DIGITS,    // inside the digits
        SCAN_DONE       // temperature finished, rest of line ignored
    } t_scan;

    // ------------------------------------------------------------------------
    // DUT and its surroundings
    // ------------------------------------------------------------------------
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_data;
    logic      out_stall = 1'b0;

    semicolon_record_parser dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_stall(out_stall)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    int unsigned idle_pct   = 0;   // chance in 100, per try, that the sender idles
    int unsigned stall_pct  = 0;   // chance in 100 the receiver stalls, drawn at each falling edge
    int unsigned errors     = 0;
    int unsigned cycles     = 0;
    int unsigned words_sent = 0;
    int unsigned records_due = 0;

    t_out_word   record_q[$];      // records still owed by the block, oldest first
    logic [7:0]  line_buf[$];      // bytes of the line about to be sent

    // directed table
    string       row_text[$];
    bit          row_typed[$];
    t_out_word   row_want[$];

    // predictor state, one line's worth
    logic [2:0]  fld;
    t_scan       scan;
    logic [15:0] acc;
    bit          neg;
    logic [15:0] year_val;
    logic [7:0]  part_val[4];      // month, day, hour, minute
    logic [1:0]  fault;
    bit          fresh;            // next byte is the first of a line
    bit          skipping;         // comment or empty line

    // field bounds for the random lines, indexed by field position
    int unsigned lim_lo[6] = '{0, 1, 1, 0, 0, 0};
    int unsigned lim_hi[6] = '{65535, 12, 31, 23, 59, 99};

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void clear_parse();
        fld      = FLD_YEAR;
        scan     = SCAN_START;
        acc      = '0;
        neg      = 1'b0;
        year_val = '0;
        foreach (part_val[i]) part_val[i] = '0;
        fault    = ST_OK;
        fresh    = 1'b1;
        skipping = 1'b0;
    endfunction

    // folds one character of a non-skipped line into the parse state
    function automatic void fold_char(logic [7:0] c);
        bit          is_digit;
        bit          is_blank;
        bit          bad;
        logic [19:0] grown;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        bad      = 1'b0;
        // a format error freezes the line, as does a finished temperature
        if (fault == ST_FORMAT || scan == SCAN_DONE) return;
        case (scan)
            SCAN_START: begin
                if (is_blank) begin
                    return;
                end else if (c == CH_PLUS) begin
                    scan = SCAN_SIGN;
                end else if (c == CH_MINUS) begin
                    // minus only on the temperature
                    if (fld == FLD_TEMP) begin
                        neg  = 1'b1;
                        scan = SCAN_SIGN;
                    end else begin
                        fault = ST_FORMAT;
                    end
                end else if (is_digit) begin
                    acc  = 16'(c - CH_ZERO);
                    scan = SCAN_DIGITS;
                end else begin
                    fault = ST_FORMAT;
                end
            end
            SCAN_SIGN: begin
                if (is_digit) begin
                    acc  = 16'(c - CH_ZERO);
                    scan = SCAN_DIGITS;
                end else begin
                    fault = ST_FORMAT;
                end
            end
            default: begin
                if (is_digit) begin
                    // year wraps at 16 bits, the rest saturate
                    grown = acc * 20'd10 + 20'(c - CH_ZERO);
                    if (fld == FLD_YEAR)
                        acc = grown[15:0];
                    else
                        acc = (grown > SAT_MAG) ? SAT_MAG[15:0] : grown[15:0];
                end else if (fld == FLD_TEMP) begin
                    scan = SCAN_DONE;
                end else if (c != CH_SEP) begin
                    fault = ST_FORMAT;
                end else begin
                    case (fld)
                        FLD_YEAR:   year_val = acc;
                        FLD_MONTH:  bad = (acc < 16'd1) || (acc > MONTH_MAX);
                        FLD_DAY:    bad = (acc < 16'd1) || (acc > DAY_MAX);
                        FLD_HOUR:   bad = (acc > HOUR_MAX);
                        default:    bad = (acc > MINUTE_MAX);
                    endcase
                    if (fld != FLD_YEAR)
                        part_val[2'(fld - FLD_MONTH)] = bad ? 8'd0 : acc[7:0];
                    // first range error is kept, a later format error overrides
                    if (bad && fault == ST_OK) fault = ST_RANGE;
                    fld  = fld + 3'd1;
                    scan = SCAN_START;
                    acc  = '0;
                    neg  = 1'b0;
                end
            end
        endcase
    endfunction

    // returns 1 with the expected record when the word closes a reported line
    function automatic bit predict_word(t_in_word w, output t_out_word rec);
        logic [1:0] st;
        logic [7:0] mag;
        rec = '0;
        if (fresh && (w.char_in == CH_HASH || w.char_in == CH_NEWLINE)) skipping = 1'b1;
        fresh = 1'b0;
        if (!skipping) fold_char(w.char_in);
        if (!w.line_last) return 1'b0;
        if (skipping) begin
            clear_parse();
            return 1'b0;
        end
        // format first: unfinished fields, or no temperature digit yet
        if (fault == ST_FORMAT || fld != FLD_TEMP || scan == SCAN_START || scan == SCAN_SIGN)
            st = ST_FORMAT;
        else if (acc > TEMP_MAX || fault == ST_RANGE)
            st = ST_RANGE;
        else
            st = ST_OK;
        rec.status = st;
        if (st == ST_OK) begin
            mag            = acc[7:0];
            rec.year_out   = year_val;
            rec.month_out  = part_val[0][3:0];
            rec.day_out    = part_val[1][4:0];
            rec.hour_out   = part_val[2][4:0];
            rec.minute_out = part_val[3][5:0];
            rec.temp_out   = neg ? -mag : mag;
        end
        clear_parse();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------------
    function automatic t_out_word make_rec(logic [1:0] st, int yr, int mo, int dy,
                                           int hr, int mi, int tp);
        t_out_word r;
        r.status     = st;
        r.year_out   = yr[15:0];
        r.month_out  = mo[3:0];
        r.day_out    = dy[4:0];
        r.hour_out   = hr[4:0];
        r.minute_out = mi[5:0];
        r.temp_out   = tp[7:0];
        return r;
    endfunction

    function automatic void add_row(string s, bit typed, t_out_word want);
        row_text.push_back(s);
        row_typed.push_back(typed);
        row_want.push_back(want);
    endfunction

    // ------------------------------------------------------------------------
    // Random line builders
    // ------------------------------------------------------------------------
    function automatic logic [7:0] blank_char();
        int unsigned k;
        k = $urandom_range(0, 5);
        // tab, LF, VT, FF, CR or space; LF heading a line makes it an empty line
        return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
    endfunction

    function automatic void put_number(int unsigned v);
        logic [7:0] digits[$];
        do begin
            digits.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[i]) line_buf.push_back(digits[i]);
    endfunction

    // one field: optional blanks, optional sign, a value, then its terminator
    function automatic void put_field(int k);
        int unsigned mode;
        int unsigned v;
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) line_buf.push_back(blank_char());
        case ($urandom_range(0, 39))
            0, 1: line_buf.push_back(CH_PLUS);
            2:    line_buf.push_back(CH_MINUS);
            default: if (k == FLD_TEMP && $urandom_range(0, 2) == 0)
                         line_buf.push_back(CH_MINUS);
        endcase
        mode = $urandom_range(0, 19);
        if (mode < 14)
            v = $urandom_range(lim_lo[k], lim_hi[k]);
        else if (mode < 17)
            v = mode[0] ? lim_hi[k] : lim_lo[k];
        else if (mode < 19)
            v = (mode == 17 && lim_lo[k] > 0) ? lim_lo[k] - 1 : lim_hi[k] + 1;
        else
            v = $urandom_range(0, 999999);
        if ($urandom_range(0, 9) == 0) line_buf.push_back(CH_ZERO);
        put_number(v);
        if (k != FLD_TEMP) begin
            line_buf.push_back(($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255))
                                                           : CH_SEP);
        end else if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // mostly well-formed records; some cut short, some noise, some skipped lines
    function automatic void build_random_line();
        int unsigned kind;
        int unsigned keep;
        kind = $urandom_range(0, 19);
        line_buf.delete();
        if (kind < 17) begin
            for (int k = 0; k < 6; k++) put_field(k);
            if (kind >= 15) begin
                keep = $urandom_range(1, line_buf.size());
                while (line_buf.size() > keep) void'(line_buf.pop_back());
            end
        end else if (kind < 19) begin
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            line_buf.push_back($urandom_range(0, 1) ? CH_HASH : CH_NEWLINE);
            repeat ($urandom_range(0, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    // Called at a falling edge; returns at the falling edge after acceptance.
    // A typed row's own record replaces the predicted one.
    task automatic send_word(t_in_word w, bit typed, t_out_word want);
        t_out_word rec;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        words_sent++;
        if (predict_word(w, rec)) begin
            record_q.push_back(typed ? want : rec);
            records_due++;
        end
        @(negedge clk);
    endtask

    task automatic send_line(bit typed, t_out_word want);
        t_in_word w;
        foreach (line_buf[i]) begin
            w.char_in   = line_buf[i];
            w.line_last = (i == line_buf.size() - 1);
            send_word(w, typed, want);
        end
    endtask

    // holds the sender off until every owed record has come out; the final
    // wait keeps the next valid from landing in the same step as this one
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (record_q.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall, changed at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

    // ------------------------------------------------------------------------
    // Result check and watchdog, both on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        t_out_word want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("semicolon_record_parser test failed");
            $finish;
        end
        if (rst_n && out_valid && !out_stall) begin
            if (record_q.size() == 0) begin
                $error("record out with none expected: %h", out_data);
                errors++;
            end else begin
                want = record_q.pop_front();
                if (out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    errors++;
                end
                if (out_data.year_out !== want.year_out) begin
                    $error("year_out: expected %0d, got %0d", want.year_out, out_data.year_out);
                    errors++;
                end
                if (out_data.month_out !== want.month_out) begin
                    $error("month_out: expected %0d, got %0d", want.month_out,
                           out_data.month_out);
                    errors++;
                end
                if (out_data.day_out !== want.day_out) begin
                    $error("day_out: expected %0d, got %0d", want.day_out, out_data.day_out);
                    errors++;
                end
                if (out_data.hour_out !== want.hour_out) begin
                    $error("hour_out: expected %0d, got %0d", want.hour_out, out_data.hour_out);
                    errors++;
                end
                if (out_data.minute_out !== want.minute_out) begin
                    $error("minute_out: expected %0d, got %0d", want.minute_out,
                           out_data.minute_out);
                    errors++;
                end
                if (out_data.temp_out !== want.temp_out) begin
                    $error("temp_out: expected %0d, got %0d", want.temp_out, out_data.temp_out);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned line_no;
        int unsigned words_start;
        int unsigned records_start;

        clear_parse();

        // Directed lines. Typed records: extremes, wrap, bad values, signs.
        add_row("65535;12;31;23;59;99", 1'b1, make_rec(ST_OK, 65535, 12, 31, 23, 59, 99));
        add_row("0;1;1;0;0;-99", 1'b1, make_rec(ST_OK, 0, 1, 1, 0, 0, -99));
        add_row("65536;1;1;0;0;0", 1'b1, make_rec(ST_OK, 0, 1, 1, 0, 0, 0));
        add_row("7;1;1;1;1;-0", 1'b1, make_rec(ST_OK, 7, 1, 1, 1, 1, 0));
        add_row("2024;13;1;1;1;1", 1'b1, make_rec(ST_RANGE, 0, 0, 0, 0, 0, 0));
        add_row("2024;1;1;1;1;100", 1'b1, make_rec(ST_RANGE, 0, 0, 0, 0, 0, 0));
        add_row("2024;-1;1;1;1;1", 1'b1, make_rec(ST_FORMAT, 0, 0, 0, 0, 0, 0));
        add_row("x", 1'b1, make_rec(ST_FORMAT, 0, 0, 0, 0, 0, 0));
        // format beats an earlier range error
        add_row("2024;13;1;1;1;+", 1'b1, make_rec(ST_FORMAT, 0, 0, 0, 0, 0, 0));
        // the rest go through the predictor
        add_row(" 2024;\t3;\0157;\01312;\01430; +25 C", 1'b0, '0);  // blanks before fields
        add_row("+2024;+3;+7;+1;+1;+1", 1'b0, '0);
        add_row("2024; 3;+7 ;1;1;1", 1'b0, '0);          // blank after digits
        add_row("2024;1;1;1;1", 1'b0, '0);               // ends before temperature
        add_row("2024;1;1;1;1;-", 1'b0, '0);             // sign with no digit
        add_row("2024;1;1;1;1;+-3", 1'b0, '0);
        add_row("-2024;1;1;1;1;1", 1'b0, '0);            // minus on the year
        add_row("2024;0;40;24;60;5", 1'b0, '0);
        add_row("2024;99999;1;1;1;1", 1'b0, '0);         // saturates, then out of range
        add_row("2024;1;1;1;1;999", 1'b0, '0);
        add_row("2024;1;1;1;1;5x;junk", 1'b0, '0);       // tail after temperature
        add_row("2024#;1;1;1;1;1", 1'b0, '0);
        add_row(";", 1'b0, '0);
        add_row("#2024;1;1;1;1;1", 1'b0, '0);            // comment: no record
        add_row("\n", 1'b0, '0);                         // empty line: no record
        add_row("\n2024;1;1;1;1;1", 1'b0, '0);

        // reset held from the start, released on a falling edge
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < row_text.size(); r++) begin
            line_buf.delete();
            for (int i = 0; i < row_text[r].len(); i++) line_buf.push_back(row_text[r][i]);
            send_line(row_typed[r], row_want[r]);
        end

        // let the directed records out before the random traffic starts
        wait_drained();

        // Random lines. Idling changes every two lines: none, sender only,
        // receiver only, then a little of both.
        line_no       = 0;
        words_start   = words_sent;
        records_start = records_due;
        while (words_sent - words_start < RANDOM_WORDS ||
               records_due - records_start < RANDOM_RECORDS) begin
            case ((line_no / 2) % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 46; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            if ($urandom_range(0, 24) == 0) wait_drained();
            build_random_line();
            send_line(1'b0, '0);
            line_no++;
        end

        // drain, then give any stray record time to show up
        wait_drained();
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("semicolon_record_parser test passed");
        else
            $display("semicolon_record_parser test failed");
        $finish;
    end

endmodule

`default_nettype wire
